// ===== sv/snell_refraction_vector_unit_defines.svh =====
// ----------------------------------------------------------------------------
// snell refraction vector unit assertion macros
// shared property wrappers clocked on aclk, off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef SNELL_REFRACTION_VECTOR_UNIT_DEFINES_SVH
`define SNELL_REFRACTION_VECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define SRV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/srv_pkg.sv =====
// ----------------------------------------------------------------------------
// srv_pkg
// widths, constants and sideband types of the refraction pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package srv_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = IN_W + 2;
    localparam int ETA_IP_W  = 19;          // eta*i and eta*cos_i products
    localparam int SQ_IN_W   = 36;          // radicand, even width
    localparam int SQ_OUT_W  = SQ_IN_W / 2; // root
    localparam int SQ_REM_W  = SQ_OUT_W + 2;
    localparam int SQ_STAGES = SQ_OUT_W;

    localparam int ONE = 1 << FRAC_BITS;

    // values that ride alongside the square root
    typedef struct packed {
        logic [2:0][IN_W-1:0]     nv;
        logic [2:0][ETA_IP_W-1:0] ei;
        logic [ETA_IP_W-1:0]      eci;
        logic                     tir;
    } sqrt_sb_t;

endpackage

`default_nettype wire

// ===== sv/srv_sqrt.sv =====
// ----------------------------------------------------------------------------
// srv_sqrt
// pipelined floor square root, one result bit per stage, with sideband
// ----------------------------------------------------------------------------
`default_nettype none

module srv_sqrt (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [srv_pkg::SQ_IN_W-1:0]  in_radicand,
    input  wire srv_pkg::sqrt_sb_t            in_sb,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [srv_pkg::SQ_OUT_W-1:0]      out_root,
    output srv_pkg::sqrt_sb_t                 out_sb
);

    localparam int N  = srv_pkg::SQ_STAGES;
    localparam int RW = srv_pkg::SQ_REM_W;
    localparam int QW = srv_pkg::SQ_OUT_W;
    localparam int DW = srv_pkg::SQ_IN_W;

    logic                v_reg    [N];
    logic [DW-1:0]       rad_reg  [N];
    logic [QW-1:0]       root_reg [N];
    logic [RW-1:0]       rem_reg  [N];
    srv_pkg::sqrt_sb_t   sb_reg   [N];

    logic                rdy      [N];
    logic [DW-1:0]       rad_next [N];
    logic [QW-1:0]       root_next[N];
    logic [RW-1:0]       rem_next [N];

    // stall chain, a stage moves when the one after it is empty or moving
    always_comb begin
        rdy[N-1] = !v_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    // one restoring step per stage
    always_comb begin
        logic [DW-1:0]  rin;
        logic [QW-1:0]  qin;
        logic [RW-1:0]  remin;
        logic [RW+1:0]  trial;
        logic [RW+1:0]  test;
        for (int i = 0; i < N; i++) begin
            if (i == 0) begin
                rin   = in_radicand;
                qin   = '0;
                remin = '0;
            end else begin
                rin   = rad_reg[i-1];
                qin   = root_reg[i-1];
                remin = rem_reg[i-1];
            end
            trial = {remin, rin[DW-1 -: 2]};
            test  = {2'b00, qin, 2'b01};
            rad_next[i] = {rin[DW-3:0], 2'b00};
            if (trial >= test) begin
                rem_next[i]  = RW'(trial - test);
                root_next[i] = {qin[QW-2:0], 1'b1};
            end else begin
                rem_next[i]  = RW'(trial);
                root_next[i] = {qin[QW-2:0], 1'b0};
            end
        end
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                v_reg[i] <= (i == 0) ? in_valid : v_reg[i-1 < 0 ? 0 : i-1];
            end
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            if (rdy[i]) begin
                rad_reg[i]  <= rad_next[i];
                root_reg[i] <= root_next[i];
                rem_reg[i]  <= rem_next[i];
                sb_reg[i]   <= (i == 0) ? in_sb : sb_reg[i-1 < 0 ? 0 : i-1];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_sb    = sb_reg[N-1];

endmodule

`default_nettype wire

// ===== sv/snell_refraction_vector_unit.sv =====
// ----------------------------------------------------------------------------
// snell_refraction_vector_unit
// fixed-point snell refraction t = eta*i + (eta*cos_i - cos_t)*n
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one query per transaction: incident vector, surface
//   normal (signed q2.14) and index ratio eta (unsigned q2.14).
//   m_ channel returns the refracted vector (signed q4.14, saturated) in
//   m_tdata and the total internal reflection flag in m_tuser; on
//   reflection the vector is zero.
//   an accepted s_ transaction passes through 5 stages of dot product,
//   cosine, sin squared and radicand, 18 stages of the square root (one
//   root bit per stage), then k, k*n and the output register.
//   throughput is one query per cycle while the receiver keeps m_tready
//   high; queries are independent.
//   when m_tready is low, results stay in the output register and the
//   pipeline keeps filling its empty stages; s_tready drops only once the
//   first stage is occupied and cannot move.
//   reset (aresetn low, synchronous) empties every stage; no results are
//   pending after it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "snell_refraction_vector_unit_defines.svh"

module snell_refraction_vector_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z,
    // index_ratio (16 bits each, from bit 0 up)
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // refracted_x, refracted_y, refracted_z (18 bits each), 2 zero bits
    output logic [55:0]       m_tdata,
    // total_reflection
    output logic [0:0]        m_tuser
);

    localparam int FB  = srv_pkg::FRAC_BITS;
    localparam int IW  = srv_pkg::IN_W;
    localparam int OW  = srv_pkg::OUT_W;
    localparam int EW  = srv_pkg::ETA_IP_W;
    localparam int DW  = srv_pkg::SQ_IN_W;
    localparam int QW  = srv_pkg::SQ_OUT_W;
    localparam int SW  = 24;                // sin squared t
    localparam int KW  = EW + 1;            // k
    localparam int KNW = KW + IW - FB;      // k*n after shift

    // stage valids and stall chain
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg, g_v_reg, h_v_reg;
    logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, f_rdy, g_rdy, h_rdy;
    logic sq_in_ready, sq_out_valid;

    assign h_rdy = !h_v_reg || m_tready;
    assign g_rdy = !g_v_reg || h_rdy;
    assign f_rdy = !f_v_reg || g_rdy;
    assign e_rdy = !e_v_reg || sq_in_ready;
    assign d_rdy = !d_v_reg || e_rdy;
    assign c_rdy = !c_v_reg || d_rdy;
    assign b_rdy = !b_v_reg || c_rdy;
    assign a_rdy = !a_v_reg || b_rdy;
    assign s_tready = a_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
        end else begin
            if (a_rdy) a_v_reg <= s_tvalid;
            if (b_rdy) b_v_reg <= a_v_reg;
            if (c_rdy) c_v_reg <= b_v_reg;
            if (d_rdy) d_v_reg <= c_v_reg;
            if (e_rdy) e_v_reg <= d_v_reg;
            if (f_rdy) f_v_reg <= sq_out_valid;
            if (g_rdy) g_v_reg <= f_v_reg;
            if (h_rdy) h_v_reg <= g_v_reg;
        end
    end

    // stage a: i*n terms, eta^2, eta*i
    logic signed [IW-1:0]   a_nv_next [3];
    logic signed [IW+1:0]   a_pin_next[3];
    logic signed [EW-1:0]   a_ei_next [3];
    logic [IW+1:0]          a_eta2_next;
    logic signed [IW-1:0]   a_nv_reg  [3];
    logic signed [IW+1:0]   a_pin_reg [3];
    logic signed [EW-1:0]   a_ei_reg  [3];
    logic [IW+1:0]          a_eta2_reg;
    logic [IW-1:0]          a_eta_reg;

    always_comb begin
        logic signed [IW-1:0]   iv;
        logic signed [2*IW-1:0] p;
        logic signed [2*IW:0]   pe;
        logic [2*IW-1:0]        pu;
        for (int c = 0; c < 3; c++) begin
            iv            = $signed(s_tdata[IW*c +: IW]);
            a_nv_next[c]  = $signed(s_tdata[IW*(c+3) +: IW]);
            p             = iv * a_nv_next[c];
            a_pin_next[c] = (IW+2)'(p >>> FB);
            pe            = $signed({1'b0, s_tdata[IW*6 +: IW]}) * iv;
            a_ei_next[c]  = EW'(pe >>> FB);
        end
        pu          = s_tdata[IW*6 +: IW] * s_tdata[IW*6 +: IW];
        a_eta2_next = (IW+2)'(pu >> FB);
    end

    always_ff @(posedge aclk) begin
        if (a_rdy) begin
            a_nv_reg   <= a_nv_next;
            a_pin_reg  <= a_pin_next;
            a_ei_reg   <= a_ei_next;
            a_eta2_reg <= a_eta2_next;
            a_eta_reg  <= s_tdata[IW*6 +: IW];
        end
    end

    // stage b: cos_i = -dot, clamped to the input range
    logic signed [IW-1:0] b_ci_next, b_ci_reg;
    logic signed [IW-1:0] b_nv_reg[3];
    logic signed [EW-1:0] b_ei_reg[3];
    logic [IW+1:0]        b_eta2_reg;
    logic [IW-1:0]        b_eta_reg;

    always_comb begin
        logic signed [IW+4:0] nd;
        nd = -((IW+5)'(a_pin_reg[0]) + (IW+5)'(a_pin_reg[1]) + (IW+5)'(a_pin_reg[2]));
        if (nd > (IW+5)'((1 << (IW-1)) - 1)) begin
            b_ci_next = {1'b0, {(IW-1){1'b1}}};
        end else if (nd < -(IW+5)'(1 << (IW-1))) begin
            b_ci_next = {1'b1, {(IW-1){1'b0}}};
        end else begin
            b_ci_next = IW'(nd);
        end
    end

    always_ff @(posedge aclk) begin
        if (b_rdy) begin
            b_ci_reg   <= b_ci_next;
            b_nv_reg   <= a_nv_reg;
            b_ei_reg   <= a_ei_reg;
            b_eta2_reg <= a_eta2_reg;
            b_eta_reg  <= a_eta_reg;
        end
    end

    // stage c: 1 - cos_i^2, eta*cos_i
    logic signed [IW+2:0] c_om_next, c_om_reg;
    logic signed [EW-1:0] c_eci_next, c_eci_reg;
    logic signed [IW-1:0] c_nv_reg[3];
    logic signed [EW-1:0] c_ei_reg[3];
    logic [IW+1:0]        c_eta2_reg;

    always_comb begin
        logic signed [2*IW-1:0] cc;
        logic signed [2*IW:0]   pe;
        cc         = b_ci_reg * b_ci_reg;
        c_om_next  = (IW+3)'(srv_pkg::ONE) - (IW+3)'(cc >>> FB);
        pe         = $signed({1'b0, b_eta_reg}) * b_ci_reg;
        c_eci_next = EW'(pe >>> FB);
    end

    always_ff @(posedge aclk) begin
        if (c_rdy) begin
            c_om_reg   <= c_om_next;
            c_eci_reg  <= c_eci_next;
            c_nv_reg   <= b_nv_reg;
            c_ei_reg   <= b_ei_reg;
            c_eta2_reg <= b_eta2_reg;
        end
    end

    // stage d: sin^2 t = eta^2 * (1 - cos_i^2)
    logic signed [SW-1:0] d_sin2_next, d_sin2_reg;
    logic signed [IW-1:0] d_nv_reg[3];
    logic signed [EW-1:0] d_ei_reg[3];
    logic signed [EW-1:0] d_eci_reg;

    always_comb begin
        logic signed [2*IW+5:0] p;
        p           = $signed({1'b0, c_eta2_reg}) * c_om_reg;
        d_sin2_next = SW'(p >>> FB);
    end

    always_ff @(posedge aclk) begin
        if (d_rdy) begin
            d_sin2_reg <= d_sin2_next;
            d_nv_reg   <= c_nv_reg;
            d_ei_reg   <= c_ei_reg;
            d_eci_reg  <= c_eci_reg;
        end
    end

    // stage e: reflection test and square root radicand
    logic [DW-1:0]     e_rad_next, e_rad_reg;
    srv_pkg::sqrt_sb_t e_sb_next, e_sb_reg;

    always_comb begin
        logic signed [SW-1:0] rad;
        rad           = SW'(srv_pkg::ONE) - d_sin2_reg;
        e_sb_next.tir = d_sin2_reg > SW'(srv_pkg::ONE);
        e_sb_next.eci = d_eci_reg;
        for (int c = 0; c < 3; c++) begin
            e_sb_next.nv[c] = d_nv_reg[c];
            e_sb_next.ei[c] = d_ei_reg[c];
        end
        if (e_sb_next.tir) begin
            e_rad_next = '0;
        end else begin
            e_rad_next = DW'({rad[SW-2:0], {FB{1'b0}}});
        end
    end

    always_ff @(posedge aclk) begin
        if (e_rdy) begin
            e_rad_reg <= e_rad_next;
            e_sb_reg  <= e_sb_next;
        end
    end

    // cos_t by square root
    logic [QW-1:0]     sq_root;
    srv_pkg::sqrt_sb_t sq_sb;

    srv_sqrt u_sqrt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (e_v_reg),
        .in_ready    (sq_in_ready),
        .in_radicand (e_rad_reg),
        .in_sb       (e_sb_reg),
        .out_valid   (sq_out_valid),
        .out_ready   (f_rdy),
        .out_root    (sq_root),
        .out_sb      (sq_sb)
    );

    // stage f: k = eta*cos_i - cos_t
    logic signed [KW-1:0] f_k_reg;
    srv_pkg::sqrt_sb_t    f_sb_reg;

    always_ff @(posedge aclk) begin
        if (f_rdy) begin
            f_k_reg  <= KW'($signed(sq_sb.eci)) - $signed({1'b0, sq_root});
            f_sb_reg <= sq_sb;
        end
    end

    // stage g: k*n
    logic signed [KNW-1:0] g_kn_next[3];
    logic signed [KNW-1:0] g_kn_reg [3];
    logic signed [EW-1:0]  g_ei_reg [3];
    logic                  g_tir_reg;

    always_comb begin
        logic signed [KW+IW-1:0] p;
        for (int c = 0; c < 3; c++) begin
            p            = f_k_reg * $signed(f_sb_reg.nv[c]);
            g_kn_next[c] = KNW'(p >>> FB);
        end
    end

    always_ff @(posedge aclk) begin
        if (g_rdy) begin
            g_kn_reg  <= g_kn_next;
            for (int c = 0; c < 3; c++) begin
                g_ei_reg[c] <= $signed(f_sb_reg.ei[c]);
            end
            g_tir_reg <= f_sb_reg.tir;
        end
    end

    // stage h: sum, saturate, output register
    logic [OW-1:0] h_t_next[3];
    logic [OW-1:0] h_t_reg [3];
    logic          h_tir_reg;

    always_comb begin
        logic signed [KNW:0] t;
        for (int c = 0; c < 3; c++) begin
            t = (KNW+1)'(g_ei_reg[c]) + (KNW+1)'(g_kn_reg[c]);
            if (g_tir_reg) begin
                h_t_next[c] = '0;
            end else if (t > (KNW+1)'((1 << (OW-1)) - 1)) begin
                h_t_next[c] = {1'b0, {(OW-1){1'b1}}};
            end else if (t < -(KNW+1)'(1 << (OW-1))) begin
                h_t_next[c] = {1'b1, {(OW-1){1'b0}}};
            end else begin
                h_t_next[c] = OW'(t);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (h_rdy) begin
            h_t_reg   <= h_t_next;
            h_tir_reg <= g_tir_reg;
        end
    end

    assign m_tvalid = h_v_reg;
    assign m_tdata  = {2'b00, h_t_reg[2], h_t_reg[1], h_t_reg[0]};
    assign m_tuser  = h_tir_reg;

    // checks
    `SRV_ASSERT_IMP(a_reflect_zero, m_tvalid && m_tuser[0], m_tdata == '0, "reflection with nonzero vector")
    `SRV_ASSERT_IMP(a_stall_full, !s_tready, a_v_reg && b_v_reg, "input stalled with free stage")
    `SRV_ASSERT_IMP(a_tir_radicand, e_v_reg && e_sb_reg.tir, e_rad_reg == '0, "radicand on reflection")
    `SRV_ASSERT_NXT(a_accept_loads, s_tvalid && s_tready, a_v_reg, "accepted transaction lost")

endmodule

`default_nettype wire
